@@ rtl/core/dasub_pkg.sv @@
// Shared types and constants for the decimal add/subtract block.
// No dependencies.
package dasub_pkg;

    localparam int MANT_W  = 96;
    localparam int SCALE_W = 5;
    localparam int WORD_W  = 32;
    localparam int REM_W   = 4;

    // floor(x / 10) == (x * DIV10_MUL) >> DIV10_SHIFT for every x below 2^38
    localparam int DIV10_SHIFT = 39;
    localparam logic [35:0] DIV10_MUL = 36'd54975581389;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [1:0] STATUS_TOO_SMALL = 2'd2;

    // Classified operation: x is the operand to be scaled up by cnt decades.
    typedef struct packed {
        logic [MANT_W-1:0]  x_mant;
        logic [MANT_W-1:0]  y_mant;
        logic               x_neg;
        logic               y_neg;
        logic [SCALE_W-1:0] cnt;
        logic [SCALE_W-1:0] scale;
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_COMBINE,
        ST_CHECK,
        ST_DIV,
        ST_ROUND,
        ST_DONE
    } back_state_t;

endpackage

@@ rtl/core/dasub_front.sv @@
// Front end: accepts requests, applies the subtract sign flip and picks
// the operand to align. Depends on dasub_pkg.
module dasub_front
(
    input  logic                            req_type,
    input  logic [63:0]                     a_low,
    input  logic [31:0]                     a_high,
    input  logic [dasub_pkg::SCALE_W-1:0]   a_scale,
    input  logic                            a_negative,
    input  logic [63:0]                     b_low,
    input  logic [31:0]                     b_high,
    input  logic [dasub_pkg::SCALE_W-1:0]   b_scale,
    input  logic                            b_negative,
    output dasub_pkg::op_t                  op
);

    logic b_neg_eff;
    logic a_smaller;

    assign b_neg_eff = b_negative ^ req_type;
    assign a_smaller = (a_scale < b_scale);

    always_comb
    begin
        if (a_smaller)
        begin
            op.x_mant = {a_high, a_low};
            op.x_neg  = a_negative;
            op.y_mant = {b_high, b_low};
            op.y_neg  = b_neg_eff;
            op.cnt    = b_scale - a_scale;
            op.scale  = b_scale;
        end
        else
        begin
            op.x_mant = {b_high, b_low};
            op.x_neg  = b_neg_eff;
            op.y_mant = {a_high, a_low};
            op.y_neg  = a_negative;
            op.cnt    = a_scale - b_scale;
            op.scale  = a_scale;
        end
    end

endmodule

@@ rtl/core/dasub_queue.sv @@
// Two-entry queue between front end and back end.
// Depends on dasub_pkg.
module dasub_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  dasub_pkg::op_t  push_op,
    output logic            pop_valid,
    input  logic            pop_ready,
    output dasub_pkg::op_t  pop_op
);

    dasub_pkg::op_t entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_op     = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ rtl/core/dasub_back.sv @@
// Back end: scale alignment, add/subtract, divide-by-ten normalization,
// rounding and the output register. Depends on dasub_pkg.
module dasub_back
#(
    parameter int MAX_SCALE  = 28,
    parameter int WIDE_WORDS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            op_valid,
    output logic                            op_ready,
    input  dasub_pkg::op_t                  op,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [63:0]                     sum_low,
    output logic [31:0]                     sum_high,
    output logic [dasub_pkg::SCALE_W-1:0]   sum_scale,
    output logic                            sum_negative,
    output logic [1:0]                      status
);

    localparam int W     = WIDE_WORDS * dasub_pkg::WORD_W;
    localparam int IDX_W = $clog2(WIDE_WORDS);
    localparam int MW    = dasub_pkg::MANT_W;
    localparam int SW    = dasub_pkg::SCALE_W;
    localparam int RW    = dasub_pkg::REM_W;

    dasub_pkg::back_state_t state_reg, state_next;

    logic [W-1:0]     x_reg, x_next;
    logic [W-1:0]     y_reg, y_next;
    logic             x_neg_reg, x_neg_next;
    logic             y_neg_reg, y_neg_next;
    logic             neg_reg, neg_next;
    logic [SW-1:0]    cnt_reg, cnt_next;
    logic [SW-1:0]    scale_reg, scale_next;
    logic [RW-1:0]    last_reg, last_next;
    logic             sticky_reg, sticky_next;
    logic             seen_reg, seen_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [RW-1:0]    rem_reg, rem_next;

    logic             out_valid_reg, out_valid_next;
    logic [MW-1:0]    out_mant_reg, out_mant_next;
    logic [SW-1:0]    out_scale_reg, out_scale_next;
    logic             out_neg_reg, out_neg_next;
    logic [1:0]       out_status_reg, out_status_next;

    logic [W:0]       diff_xy;
    logic             above96;
    logic             need_div;
    logic             round_up;
    logic [35:0]      cur;
    logic [71:0]      prod;
    logic [31:0]      quot;
    logic [35:0]      quot10;
    logic [35:0]      rem_full;
    logic             out_free;

    assign diff_xy  = {1'b0, x_reg} - {1'b0, y_reg};
    assign above96  = |x_reg[W-1:MW];
    assign need_div = (scale_reg != '0) && ((scale_reg > SW'(MAX_SCALE)) || above96);
    assign round_up = (last_reg > RW'(5))
                   || ((last_reg == RW'(5)) && (sticky_reg || x_reg[0]));

    // One 32-bit word of the divide by ten per cycle, high word first
    assign cur      = {rem_reg, x_reg[widx_reg * dasub_pkg::WORD_W +: dasub_pkg::WORD_W]};
    assign prod     = 72'(cur) * 72'(dasub_pkg::DIV10_MUL);
    assign quot     = prod[dasub_pkg::DIV10_SHIFT +: 32];
    assign quot10   = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
    assign rem_full = cur - quot10;
    assign out_free = !out_valid_reg || out_ready;

    assign op_ready     = (state_reg == dasub_pkg::ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign sum_low      = out_mant_reg[63:0];
    assign sum_high     = out_mant_reg[MW-1:64];
    assign sum_scale    = out_scale_reg;
    assign sum_negative = out_neg_reg;
    assign status       = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        x_neg_next      = x_neg_reg;
        y_neg_next      = y_neg_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        scale_next      = scale_reg;
        last_next       = last_reg;
        sticky_next     = sticky_reg;
        seen_next       = seen_reg;
        widx_next       = widx_reg;
        rem_next        = rem_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_mant_next   = out_mant_reg;
        out_scale_next  = out_scale_reg;
        out_neg_next    = out_neg_reg;
        out_status_next = out_status_reg;

        unique case (state_reg)
            dasub_pkg::ST_IDLE:
            begin
                if (op_valid)
                begin
                    x_next      = W'(op.x_mant);
                    y_next      = W'(op.y_mant);
                    x_neg_next  = op.x_neg;
                    y_neg_next  = op.y_neg;
                    cnt_next    = op.cnt;
                    scale_next  = op.scale;
                    last_next   = '0;
                    sticky_next = 1'b0;
                    seen_next   = 1'b0;
                    state_next  = dasub_pkg::ST_ALIGN;
                end
            end
            dasub_pkg::ST_ALIGN:
            begin
                if (cnt_reg != '0)
                begin
                    x_next   = {x_reg[W-4:0], 3'b000} + {x_reg[W-2:0], 1'b0};
                    cnt_next = cnt_reg - SW'(1);
                end
                else
                begin
                    state_next = dasub_pkg::ST_COMBINE;
                end
            end
            dasub_pkg::ST_COMBINE:
            begin
                if (x_neg_reg == y_neg_reg)
                begin
                    x_next   = x_reg + y_reg;
                    neg_next = x_neg_reg;
                end
                else if (x_reg == y_reg)
                begin
                    x_next   = '0;
                    neg_next = 1'b0;
                end
                else if (!diff_xy[W])
                begin
                    x_next   = diff_xy[W-1:0];
                    neg_next = x_neg_reg;
                end
                else
                begin
                    x_next   = y_reg - x_reg;
                    neg_next = y_neg_reg;
                end
                state_next = dasub_pkg::ST_CHECK;
            end
            dasub_pkg::ST_CHECK:
            begin
                if (need_div)
                begin
                    widx_next  = IDX_W'(WIDE_WORDS - 1);
                    rem_next   = '0;
                    state_next = dasub_pkg::ST_DIV;
                end
                else if (seen_reg)
                begin
                    state_next = dasub_pkg::ST_ROUND;
                end
                else
                begin
                    state_next = dasub_pkg::ST_DONE;
                end
            end
            dasub_pkg::ST_DIV:
            begin
                x_next[widx_reg * dasub_pkg::WORD_W +: dasub_pkg::WORD_W] = quot;
                rem_next  = rem_full[RW-1:0];
                widx_next = widx_reg - IDX_W'(1);
                if (widx_reg == '0)
                begin
                    sticky_next = sticky_reg || (seen_reg && (last_reg != '0));
                    last_next   = rem_full[RW-1:0];
                    seen_next   = 1'b1;
                    scale_next  = scale_reg - SW'(1);
                    state_next  = dasub_pkg::ST_CHECK;
                end
            end
            dasub_pkg::ST_ROUND:
            begin
                if (round_up)
                begin
                    x_next = x_reg + W'(1);
                end
                last_next   = '0;
                sticky_next = 1'b0;
                seen_next   = 1'b0;
                state_next  = dasub_pkg::ST_CHECK;
            end
            dasub_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (above96)
                    begin
                        out_mant_next   = '0;
                        out_scale_next  = '0;
                        out_neg_next    = 1'b0;
                        out_status_next = neg_reg ? dasub_pkg::STATUS_TOO_SMALL
                                                  : dasub_pkg::STATUS_TOO_LARGE;
                    end
                    else
                    begin
                        out_mant_next   = x_reg[MW-1:0];
                        out_scale_next  = scale_reg;
                        out_neg_next    = neg_reg;
                        out_status_next = dasub_pkg::STATUS_OK;
                    end
                    state_next = dasub_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dasub_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dasub_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg          <= x_next;
        y_reg          <= y_next;
        x_neg_reg      <= x_neg_next;
        y_neg_reg      <= y_neg_next;
        neg_reg        <= neg_next;
        cnt_reg        <= cnt_next;
        scale_reg      <= scale_next;
        last_reg       <= last_next;
        sticky_reg     <= sticky_next;
        seen_reg       <= seen_next;
        widx_reg       <= widx_next;
        rem_reg        <= rem_next;
        out_mant_reg   <= out_mant_next;
        out_scale_reg  <= out_scale_next;
        out_neg_reg    <= out_neg_next;
        out_status_reg <= out_status_next;
    end

endmodule

@@ rtl/core/decimal_add_subtract_top.sv @@
// Top level of the decimal add/subtract block.
// Depends on dasub_pkg, dasub_front, dasub_queue, dasub_back.

// Adds or subtracts two 96-bit sign-magnitude decimals (mantissa / 10^scale)
// and returns one result transaction per request transaction. The front end
// classifies each request and parks it in a two-entry queue; the back end
// works on one request at a time. The back end loads the request, aligns the
// scales (one multiply-by-ten per cycle, once per decade of scale difference),
// adds or subtracts and checks the result; then each divide-by-ten step runs
// one 32-bit word per cycle through the shared reciprocal multiplier, a
// rounding pass follows the divides, and the result is written to the output
// register once that register is free. Overflow gives status too_large (1)
// or too_small (2) with zero result fields.
module decimal_add_subtract_top
#(
    parameter int MAX_SCALE  = 28,
    parameter int WIDE_WORDS = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [63:0]                     a_low,
    input  logic [31:0]                     a_high,
    input  logic [dasub_pkg::SCALE_W-1:0]   a_scale,
    input  logic                            a_negative,
    input  logic [63:0]                     b_low,
    input  logic [31:0]                     b_high,
    input  logic [dasub_pkg::SCALE_W-1:0]   b_scale,
    input  logic                            b_negative,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [63:0]                     sum_low,
    output logic [31:0]                     sum_high,
    output logic [dasub_pkg::SCALE_W-1:0]   sum_scale,
    output logic                            sum_negative,
    output logic [1:0]                      status
);

    dasub_pkg::op_t front_op;
    dasub_pkg::op_t back_op;
    logic           back_valid;
    logic           back_ready;

    dasub_front u_front
    (
        .req_type   (req_type),
        .a_low      (a_low),
        .a_high     (a_high),
        .a_scale    (a_scale),
        .a_negative (a_negative),
        .b_low      (b_low),
        .b_high     (b_high),
        .b_scale    (b_scale),
        .b_negative (b_negative),
        .op         (front_op)
    );

    dasub_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    dasub_back
    #(
        .MAX_SCALE  (MAX_SCALE),
        .WIDE_WORDS (WIDE_WORDS)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .op_valid     (back_valid),
        .op_ready     (back_ready),
        .op           (back_op),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sum_low      (sum_low),
        .sum_high     (sum_high),
        .sum_scale    (sum_scale),
        .sum_negative (sum_negative),
        .status       (status)
    );

    // overflow results carry zero fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != dasub_pkg::STATUS_OK)) |->
        ((sum_low == '0) && (sum_high == '0) && (sum_scale == '0) && !sum_negative))
    else $error("overflow result with nonzero fields");

    // normalization never leaves a scale above the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == dasub_pkg::STATUS_OK)) |->
        (sum_scale <= dasub_pkg::SCALE_W'(MAX_SCALE)))
    else $error("result scale above limit");

    // status is never the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((status == dasub_pkg::STATUS_OK)
                    || (status == dasub_pkg::STATUS_TOO_LARGE)
                    || (status == dasub_pkg::STATUS_TOO_SMALL)))
    else $error("invalid status code");

endmodule

@@ tb/decimal_add_subtract_top_tb.sv @@
// Self-checking testbench for decimal_add_subtract_top: directed and random
// add/subtract transactions checked against an in-bench decimal predictor.
// Depends on dasub_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module decimal_add_subtract_top_tb;

    localparam int MAX_SCALE  = 28;
    localparam int WIDE_W     = 256;
    localparam int N_RANDOM   = 1230;

    typedef logic [WIDE_W-1:0] wide_t;

    // One input transaction.
    typedef struct {
        logic                          sub;
        logic [63:0]                   al;
        logic [31:0]                   ah;
        logic [dasub_pkg::SCALE_W-1:0] as;
        logic                          an;
        logic [63:0]                   bl;
        logic [31:0]                   bh;
        logic [dasub_pkg::SCALE_W-1:0] bs;
        logic                          bn;
    } sum_req_t;

    // One result transaction.
    typedef struct {
        logic [63:0]                   lo;
        logic [31:0]                   hi;
        logic [dasub_pkg::SCALE_W-1:0] sc;
        logic                          neg;
        logic [1:0]                    st;
    } sum_res_t;

    int error_count = 0;

    task automatic report_mismatch(input string what, input logic [95:0] got,
                                   input logic [95:0] want);
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Decimal add/subtract predictor on a 256-bit working register.
    function automatic sum_res_t decimal_sum(input sum_req_t q);
        wide_t a, b, r, lim;
        int s, sa, sb, cnt;
        logic na, nb, neg, sticky;
        logic [3:0] last;
        sum_res_t res;
        lim = wide_t'(1) << 96;
        sa = q.as; sb = q.bs;
        na = q.an; nb = q.bn ^ q.sub;
        a = {q.ah, q.al};
        b = {q.bh, q.bl};
        for (s = sa; s < sb; s++) a = a * 10;
        for (s = sb; s < sa; s++) b = b * 10;
        s = (sa > sb) ? sa : sb;
        if (na == nb) begin
            r = a + b; neg = na;
        end
        else if (a > b) begin
            r = a - b; neg = na;
        end
        else if (a < b) begin
            r = b - a; neg = nb;
        end
        else begin
            r = '0; neg = 1'b0;
        end
        forever
        begin
            last = 0; sticky = 0; cnt = 0;
            while (s > 0 && (s > MAX_SCALE || r >= lim))
            begin
                if (cnt > 0 && last != 0) sticky = 1;
                last = 4'(r % 10);
                r = r / 10;
                s--; cnt++;
            end
            // round half to even over the whole discarded part
            if (cnt > 0 && (last > 5 || (last == 5 && (sticky || r[0])))) r = r + 1;
            if (!(s > 0 && r >= lim)) break;
        end
        if (r >= lim) begin
            res = '{64'd0, 32'd0, '0, 1'b0,
                    neg ? dasub_pkg::STATUS_TOO_SMALL : dasub_pkg::STATUS_TOO_LARGE};
        end
        else begin
            res = '{r[63:0], r[95:64], dasub_pkg::SCALE_W'(s), neg, dasub_pkg::STATUS_OK};
        end
        return res;
    endfunction

    class sum_scoreboard;
        sum_res_t pending[$];

        function void note_request(sum_req_t q);
            pending.push_back(decimal_sum(q));
        endfunction

        task check_result(sum_res_t g);
            sum_res_t w;
            if (pending.size() == 0) begin
                report_mismatch("unexpected transaction", {g.hi, g.lo}, '0);
                return;
            end
            w = pending.pop_front();
            if (g.lo !== w.lo) report_mismatch("sum_low", g.lo, w.lo);
            if (g.hi !== w.hi) report_mismatch("sum_high", g.hi, w.hi);
            if (g.sc !== w.sc) report_mismatch("sum_scale", g.sc, w.sc);
            if (g.neg !== w.neg) report_mismatch("sum_negative", g.neg, w.neg);
            if (g.st !== w.st) report_mismatch("status", g.st, w.st);
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0, in_ready;
    logic req_type = 0;
    logic [63:0] a_low = 0, b_low = 0;
    logic [31:0] a_high = 0, b_high = 0;
    logic [dasub_pkg::SCALE_W-1:0] a_scale = 0, b_scale = 0;
    logic a_negative = 0, b_negative = 0;
    logic out_valid, out_ready = 0;
    logic [63:0] sum_low;
    logic [31:0] sum_high;
    logic [dasub_pkg::SCALE_W-1:0] sum_scale;
    logic sum_negative;
    logic [1:0] status;

    sum_scoreboard board = new();
    int send_idle_pct = 11;
    int recv_idle_pct = 76;
    bit recv_hold = 0;

    decimal_add_subtract_top dut (.*);

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    // Result side: random stall, optional long hold-off, check on handshake.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result('{sum_low, sum_high, sum_scale, sum_negative, status});
        out_ready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Drive one transaction; valid held until accepted and dropped only
    // when the sender idles, so back-to-back transactions keep it high.
    task automatic send_request(input sum_req_t q);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        req_type <= q.sub;
        a_low <= q.al; a_high <= q.ah; a_scale <= q.as; a_negative <= q.an;
        b_low <= q.bl; b_high <= q.bh; b_scale <= q.bs; b_negative <= q.bn;
        do @(posedge clk); while (!in_ready);
        board.note_request(q);
    endtask

    function automatic logic [95:0] rand_mant();
        logic [95:0] m;
        m = {$urandom, $urandom, $urandom};
        case ($urandom_range(5))
            0: m = m >> $urandom_range(95);
            1: m = '1;
            2: m = 96'($urandom_range(20));
            3: m = m >> 64;
            default: ;
        endcase
        return m;
    endfunction

    function automatic sum_req_t rand_request();
        sum_req_t q;
        logic [95:0] ma, mb;
        ma = rand_mant();
        mb = ($urandom_range(7) == 0) ? ma : rand_mant();
        q.sub = 1'($urandom); q.an = 1'($urandom); q.bn = 1'($urandom);
        {q.ah, q.al} = ma; {q.bh, q.bl} = mb;
        // mostly legal scales, sometimes anything the 5-bit field holds
        q.as = ($urandom_range(9) == 0) ? dasub_pkg::SCALE_W'($urandom)
                                        : dasub_pkg::SCALE_W'($urandom_range(MAX_SCALE));
        q.bs = ($urandom_range(9) == 0) ? dasub_pkg::SCALE_W'($urandom)
                                        : dasub_pkg::SCALE_W'($urandom_range(MAX_SCALE));
        return q;
    endfunction

    task automatic wait_drained();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) send_request(rand_request());
    endtask

    initial
    begin
        logic [95:0] ones;
        ones = '1;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: extremes, both operations, overflow, ties, zero signs.
        send_request('{0, 64'd0, 32'd0, 0, 0, 64'd0, 32'd0, 0, 0});
        send_request('{0, 64'd0, 32'd0, 3, 1, 64'd0, 32'd0, 7, 1});          // negative zero
        send_request('{1, 64'd5, 32'd0, 2, 0, 64'd5, 32'd0, 2, 0});          // equal -> +0
        send_request('{0, ones[63:0], ones[95:64], 0, 0, 64'd1, 32'd0, 0, 0});  // too large
        send_request('{1, ones[63:0], ones[95:64], 0, 1, 64'd1, 32'd0, 0, 0});  // too small
        send_request('{0, ones[63:0], ones[95:64], 1, 0, 64'd1, 32'd0, 1, 0});  // divide back
        send_request('{0, ones[63:0], ones[95:64], 28, 0, 64'd5, 32'd0, 28, 0});
        send_request('{0, ones[63:0], ones[95:64], 0, 0, ones[63:0], ones[95:64], 28, 1});
        send_request('{1, 64'd1, 32'd0, 0, 0, ones[63:0], ones[95:64], 28, 0});
        send_request('{0, 64'd15, 32'd0, 31, 0, 64'd25, 32'd0, 30, 0});      // scale above max
        send_request('{0, 64'd5, 32'd0, 29, 0, 64'd0, 32'd0, 0, 0});         // tie to even
        send_request('{0, 64'd15, 32'd0, 29, 1, 64'd0, 32'd0, 0, 1});
        send_request('{0, 64'd51, 32'd0, 30, 0, 64'd0, 32'd0, 0, 0});        // sticky
        send_request('{1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 64'd9, 32'd0, 1, 0});
        send_request('{0, 64'd123, 32'd0, 0, 1, 64'd456, 32'd0, 28, 0});
        wait_drained();

        run_random(400);

        // Receiver holds off long enough for the queue to back up.
        recv_hold = 1;
        fork
            begin
                repeat (300) @(posedge clk);
                recv_hold = 0;
            end
            run_random(30);
        join
        wait_drained();

        send_idle_pct = 76;
        recv_idle_pct = 11;
        run_random(400);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(400);

        wait_drained();
        repeat (500) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/dasub_pkg.sv
rtl/core/dasub_front.sv
rtl/core/dasub_queue.sv
rtl/core/dasub_back.sv
rtl/core/decimal_add_subtract_top.sv
tb/decimal_add_subtract_top_tb.sv
